/* sv/irbtd_pkg.sv */
// shared types, register map and constants for the i/o register block
package irbtd_pkg;

    localparam int NUM_REGS     = 23;
    localparam int DISK_LATENCY = 1024;
    localparam int FB_SIDE      = 256;
    localparam int FB_SIZE      = FB_SIDE * FB_SIDE;
    localparam int IDX_W        = $clog2(NUM_REGS);
    localparam int DISK_CNT_W   = 11;

    localparam logic [DISK_CNT_W-1:0] DISK_LOAD = DISK_CNT_W'(DISK_LATENCY);
    localparam logic [32:0]           FB_LIMIT  = 33'(FB_SIZE);

    // command codes
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // register map
    localparam logic [4:0] REG_TIMER_EN   = 5'd0;
    localparam logic [4:0] REG_DISK_EN    = 5'd1;
    localparam logic [4:0] REG_TIMER_STAT = 5'd3;
    localparam logic [4:0] REG_DISK_STAT  = 5'd4;
    localparam logic [4:0] REG_CYCLES     = 5'd8;
    localparam logic [4:0] REG_LED        = 5'd9;
    localparam logic [4:0] REG_DISPLAY    = 5'd10;
    localparam logic [4:0] REG_MON_CMD    = 5'd11;
    localparam logic [4:0] REG_PIX_ADDR   = 5'd12;
    localparam logic [4:0] REG_PIX_DATA   = 5'd13;
    localparam logic [4:0] REG_DISK       = 5'd14;
    localparam logic [4:0] REG_TIMER_CUR  = 5'd21;
    localparam logic [4:0] REG_TIMER_MAX  = 5'd22;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [4:0]  reg_index;
        logic [31:0] wdata;
    } t_irbtd_req;

    typedef struct packed {
        logic [31:0] rdata;
        logic        fb_write;
        logic [15:0] fb_addr;
        logic [7:0]  fb_pixel;
        logic        disk_busy_out;
        logic        timer_irq;
        logic        disk_irq;
        logic [31:0] led_bits;
        logic [31:0] seg_display;
    } t_irbtd_res;

endpackage

/* sv/irbtd_core.sv */
// register file, counters, timer and disk state with the per-request update logic
module irbtd_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  irbtd_pkg::t_irbtd_req i_req,
    output irbtd_pkg::t_irbtd_res o_res
);

    logic [31:0] r_regs [irbtd_pkg::NUM_REGS];
    logic [31:0] n_regs [irbtd_pkg::NUM_REGS];
    logic [31:0] r_led, n_led;
    logic [31:0] r_display, n_display;
    logic [31:0] r_cycles, n_cycles;
    logic [irbtd_pkg::DISK_CNT_W-1:0] r_disk_cnt, n_disk_cnt;
    logic        r_disk_busy, n_disk_busy;

    logic                        in_range;
    logic [irbtd_pkg::IDX_W-1:0] idx;
    logic [irbtd_pkg::DISK_CNT_W-1:0] cnt_dec;
    logic [31:0]                 rd_val;
    logic [31:0]                 pix_addr;
    logic                        fb_hit;

    assign in_range = {27'd0, i_req.reg_index} < 32'(irbtd_pkg::NUM_REGS);
    assign idx      = i_req.reg_index[irbtd_pkg::IDX_W-1:0];
    assign cnt_dec  = r_disk_cnt - irbtd_pkg::DISK_CNT_W'(1);
    assign pix_addr = r_regs[irbtd_pkg::REG_PIX_ADDR[irbtd_pkg::IDX_W-1:0]];

    // read mux
    always_comb begin
        rd_val = '0;
        if (in_range) begin
            case (i_req.reg_index)
                irbtd_pkg::REG_CYCLES:  rd_val = r_cycles;
                irbtd_pkg::REG_LED:     rd_val = r_led;
                irbtd_pkg::REG_DISPLAY: rd_val = r_display;
                irbtd_pkg::REG_DISK:    rd_val = {31'd0, r_disk_busy};
                default:                rd_val = r_regs[idx];
            endcase
        end
    end

    // pixel write happens on monitor command 1 with an address inside the frame
    assign fb_hit = (i_req.cmd == irbtd_pkg::CMD_WRITE) && in_range
                 && (i_req.reg_index == irbtd_pkg::REG_MON_CMD)
                 && (i_req.wdata == 32'd1)
                 && ({1'b0, pix_addr} < irbtd_pkg::FB_LIMIT);

    always_comb begin
        n_regs      = r_regs;
        n_led       = r_led;
        n_display   = r_display;
        n_cycles    = r_cycles;
        n_disk_cnt  = r_disk_cnt;
        n_disk_busy = r_disk_busy;
        case (i_req.cmd)
            irbtd_pkg::CMD_WRITE: begin
                if (in_range) begin
                    case (i_req.reg_index)
                        irbtd_pkg::REG_LED:     n_led = i_req.wdata;
                        irbtd_pkg::REG_DISPLAY: n_display = i_req.wdata;
                        irbtd_pkg::REG_MON_CMD: ;
                        irbtd_pkg::REG_DISK: begin
                            if (!r_disk_busy && i_req.wdata == 32'd1) begin
                                n_disk_busy = 1'b1;
                                n_disk_cnt  = irbtd_pkg::DISK_LOAD;
                            end
                        end
                        default: n_regs[idx] = i_req.wdata;
                    endcase
                end
            end
            irbtd_pkg::CMD_TICK: begin
                n_cycles = r_cycles + 32'd1;
                if (r_disk_busy) begin
                    n_disk_cnt = cnt_dec;
                    if (cnt_dec == '0) begin
                        n_disk_busy = 1'b0;
                        if (r_regs[irbtd_pkg::REG_DISK_EN[irbtd_pkg::IDX_W-1:0]] != '0)
                            n_regs[irbtd_pkg::REG_DISK_STAT[irbtd_pkg::IDX_W-1:0]] = 32'd1;
                    end
                end
                if (r_regs[irbtd_pkg::REG_TIMER_EN[irbtd_pkg::IDX_W-1:0]] != '0
                    && r_regs[irbtd_pkg::REG_TIMER_CUR[irbtd_pkg::IDX_W-1:0]]
                       == r_regs[irbtd_pkg::REG_TIMER_MAX[irbtd_pkg::IDX_W-1:0]]) begin
                    n_regs[irbtd_pkg::REG_TIMER_STAT[irbtd_pkg::IDX_W-1:0]] = 32'd1;
                    n_regs[irbtd_pkg::REG_TIMER_CUR[irbtd_pkg::IDX_W-1:0]]  = '0;
                end else if (r_regs[irbtd_pkg::REG_TIMER_CUR[irbtd_pkg::IDX_W-1:0]]
                             < r_regs[irbtd_pkg::REG_TIMER_MAX[irbtd_pkg::IDX_W-1:0]]) begin
                    n_regs[irbtd_pkg::REG_TIMER_CUR[irbtd_pkg::IDX_W-1:0]] =
                        r_regs[irbtd_pkg::REG_TIMER_CUR[irbtd_pkg::IDX_W-1:0]] + 32'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < irbtd_pkg::NUM_REGS; i++) r_regs[i] <= '0;
            r_led       <= '0;
            r_display   <= '0;
            r_cycles    <= '0;
            r_disk_cnt  <= '0;
            r_disk_busy <= 1'b0;
        end else if (i_en) begin
            r_regs      <= n_regs;
            r_led       <= n_led;
            r_display   <= n_display;
            r_cycles    <= n_cycles;
            r_disk_cnt  <= n_disk_cnt;
            r_disk_busy <= n_disk_busy;
        end
    end

    always_comb begin
        o_res.rdata         = (i_req.cmd == irbtd_pkg::CMD_READ) ? rd_val : '0;
        o_res.fb_write      = fb_hit;
        o_res.fb_addr       = fb_hit ? pix_addr[15:0] : '0;
        o_res.fb_pixel      = fb_hit ? r_regs[irbtd_pkg::REG_PIX_DATA[irbtd_pkg::IDX_W-1:0]][7:0]
                                     : '0;
        o_res.disk_busy_out = n_disk_busy;
        o_res.timer_irq     = n_regs[irbtd_pkg::REG_TIMER_STAT[irbtd_pkg::IDX_W-1:0]] != '0;
        o_res.disk_irq      = n_regs[irbtd_pkg::REG_DISK_STAT[irbtd_pkg::IDX_W-1:0]] != '0;
        o_res.led_bits      = n_led;
        o_res.seg_display   = n_display;
    end

endmodule

/* sv/io_register_block_timer_disk_fb_unit.sv */
// top level of the i/o register block: request register, core update and result register
//
// i/o register block for a small cpu: each request is a register read, a register
// write or one clock tick, and each request yields exactly one result.  registers
// 23 and up ignore writes and read as zero.  reads of 8 return the cycle counter,
// 9 the leds, 10 the display, 14 the disk busy flag; everything else comes from the
// register file.  writing 1 to register 11 reports one framebuffer pixel write
// (address from register 12, byte from register 13) on fb_write/fb_addr/fb_pixel;
// the pixel store itself lives outside this block.  writing 1 to register 14 while
// idle starts a 1024-tick disk busy period that sets register 4 at its end when
// register 1 is nonzero.  a tick bumps the cycle counter and runs the compare
// timer (registers 0, 3, 21, 22).  throughput is one request per clock while the
// result is not stalled.  an accepted request sits in the request register until
// the result slot is free or emptying; then the state update and the result
// capture happen together and the result register offers the result.  a stalled
// result keeps its slot and holds the request register; the input stalls only when
// both hold a request, so up to two requests are in flight.  no clearing pass after reset.
module io_register_block_timer_disk_fb_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  irbtd_pkg::t_irbtd_req i_in_req,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output irbtd_pkg::t_irbtd_res o_out_res
);

    logic                  r_req_valid;
    irbtd_pkg::t_irbtd_req r_req;
    logic                  r_out_valid;
    irbtd_pkg::t_irbtd_res r_out;
    irbtd_pkg::t_irbtd_res core_res;
    logic                  advance;

    // result slot is free, or its content leaves this cycle
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_req_valid && !advance;

    irbtd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_req_valid && advance),
        .i_req   (r_req),
        .o_res   (core_res)
    );

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_req_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_req <= i_in_req;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_req_valid) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

endmodule
